### sv/sfh_pkg.sv
package sfh_pkg;

  // Finish request: running hash after the last block mix plus the
  // buffered tail bytes (byte i at bits 8*i) and their count.
  typedef struct packed {
    logic [31:0] hash;
    logic [23:0] tail;
    logic [1:0]  cnt;
  } fin_req_t;

  function automatic logic [31:0] sext8(input logic [7:0] b);
    sext8 = {{24{b[7]}}, b};
  endfunction

  // Four-byte block mix: two little-endian 16-bit halves.
  function automatic logic [31:0] block_mix(input logic [31:0] h_in,
                                            input logic [23:0] pend,
                                            input logic [7:0]  b3);
    logic [31:0] h;
    logic [31:0] tmp;
    h   = h_in + {16'h0000, pend[15:0]};
    tmp = ({16'h0000, b3, pend[23:16]} << 11) ^ h;
    h   = (h << 16) ^ tmp;
    h   = h + (h >> 11);
    block_mix = h;
  endfunction

  // One-, two- or three-byte tail step.
  function automatic logic [31:0] tail_mix(input logic [31:0] h_in,
                                           input logic [23:0] tail,
                                           input logic [1:0]  cnt);
    logic [31:0] h;
    h = h_in;
    case (cnt)
      2'd3: begin
        h = h + {16'h0000, tail[15:0]};
        h = h ^ (h << 16);
        h = h ^ (sext8(tail[23:16]) << 18);
        h = h + (h >> 11);
      end
      2'd2: begin
        h = h + {16'h0000, tail[15:0]};
        h = h ^ (h << 11);
        h = h + (h >> 17);
      end
      2'd1: begin
        h = h + sext8(tail[7:0]);
        h = h ^ (h << 10);
        h = h + (h >> 1);
      end
      default: begin
        h = h_in;
      end
    endcase
    tail_mix = h;
  endfunction

  // Final avalanche, first two rounds.
  function automatic logic [31:0] aval_lo(input logic [31:0] h_in);
    logic [31:0] h;
    h = h_in ^ (h_in << 3);
    h = h + (h >> 5);
    h = h ^ (h << 4);
    h = h + (h >> 17);
    aval_lo = h;
  endfunction

  // Final avalanche, last round.
  function automatic logic [31:0] aval_hi(input logic [31:0] h_in);
    logic [31:0] h;
    h = h_in ^ (h_in << 25);
    h = h + (h >> 6);
    aval_hi = h;
  endfunction

endpackage

### sv/sfh_finish.sv
module sfh_finish (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  input  sfh_pkg::fin_req_t  req_i,
  output logic               req_ready_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [31:0]        hash_value_o
);
  import sfh_pkg::*;

  fin_req_t    s1_q;
  logic        s1_vld_q;
  logic [31:0] s2_q, s3_q, out_q;
  logic        s2_vld_q, s3_vld_q, out_vld_q;
  logic        rdy1, rdy2, rdy3, rdy_out;

  // Each stage advances when it is empty or its successor moves on.
  assign rdy_out = !out_vld_q || !out_stall_i;
  assign rdy3    = !s3_vld_q || rdy_out;
  assign rdy2    = !s2_vld_q || rdy3;
  assign rdy1    = !s1_vld_q || rdy2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (rdy1)    s1_vld_q  <= req_valid_i;
      if (rdy2)    s2_vld_q  <= s1_vld_q;
      if (rdy3)    s3_vld_q  <= s2_vld_q;
      if (rdy_out) out_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && req_valid_i) s1_q  <= req_i;
    if (rdy2 && s1_vld_q)    s2_q  <= tail_mix(s1_q.hash, s1_q.tail, s1_q.cnt);
    if (rdy3 && s2_vld_q)    s3_q  <= aval_lo(s2_q);
    if (rdy_out && s3_vld_q) out_q <= aval_hi(s3_q);
  end

  assign req_ready_o  = rdy1;
  assign out_valid_o  = out_vld_q;
  assign hash_value_o = out_q;

endmodule

### sv/byte_stream_superfasthash.sv
// Streaming 32-bit SuperFastHash, one message byte per transfer.
//
// Input channel (in_valid_i / in_stall_o): each transfer carries one byte.
// The first byte of a message also carries total_length_i, which seeds the
// hash; last_byte_i marks the final byte. A transfer with empty_message_i
// set abandons any message in progress and yields a hash of zero.
// Output channel (out_valid_o / out_stall_i): one hash per message.
//
// Throughput: one byte per cycle while in_stall_o is low. The byte-to-byte
// loop (seed, lane insert, block mix) closes combinationally on the
// accumulator registers. The hash reaches out_valid_o through a
// four-register finish pipeline (request, tail step, avalanche first
// half, avalanche second half / output register).
// A stalled receiver holds the output; the finish pipeline fills up and
// then in_stall_o rises until a slot frees.
// Reset clears the accumulator, byte buffer and all valid flags; the
// block is ready for a new message in the first cycle after reset.
module byte_stream_superfasthash (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic [31:0] total_length_i,
  input  logic        empty_message_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] hash_value_o
);
  import sfh_pkg::*;

  logic [31:0] acc_q;
  logic [23:0] pend_q;
  logic [1:0]  cnt_q;
  logic        in_msg_q;

  logic [31:0] h0, h1;
  logic [23:0] p0, p1;
  logic [1:0]  c0, c1;
  logic        accept;
  logic        req_valid;
  logic        req_ready;
  fin_req_t    req;

  assign accept = in_valid_i && !in_stall_o;

  // Seed from total_length on the first byte of a message.
  assign h0 = in_msg_q ? acc_q  : total_length_i;
  assign p0 = in_msg_q ? pend_q : 24'h000000;
  assign c0 = in_msg_q ? cnt_q  : 2'd0;

  // Fourth byte of a group runs the block mix; others drop into a lane.
  always_comb begin
    h1 = h0;
    p1 = p0;
    c1 = c0 + 2'd1;
    case (c0)
      2'd0: p1[7:0]   = data_byte_i;
      2'd1: p1[15:8]  = data_byte_i;
      2'd2: p1[23:16] = data_byte_i;
      default: begin
        h1 = block_mix(h0, p0, data_byte_i);
        p1 = 24'h000000;
        c1 = 2'd0;
      end
    endcase
  end

  // Hash state: advance on every byte, return to idle on last or empty.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= 32'h0;
      pend_q   <= 24'h0;
      cnt_q    <= 2'd0;
      in_msg_q <= 1'b0;
    end else if (accept) begin
      if (empty_message_i) begin
        acc_q    <= 32'h0;
        pend_q   <= 24'h0;
        cnt_q    <= 2'd0;
        in_msg_q <= 1'b0;
      end else if (last_byte_i) begin
        acc_q    <= h1;
        pend_q   <= 24'h0;
        cnt_q    <= 2'd0;
        in_msg_q <= 1'b0;
      end else begin
        acc_q    <= h1;
        pend_q   <= p1;
        cnt_q    <= c1;
        in_msg_q <= 1'b1;
      end
    end
  end

  // Hand the finished message to the tail/avalanche pipeline. An empty
  // message goes through as zero with no tail: the avalanche keeps it zero.
  assign req_valid = accept && (empty_message_i || last_byte_i);
  assign req.hash  = empty_message_i ? 32'h0 : h1;
  assign req.tail  = empty_message_i ? 24'h0 : p1;
  assign req.cnt   = empty_message_i ? 2'd0  : c1;

  // Hold input transfers while the finish pipeline cannot take a request.
  assign in_stall_o = !req_ready;

  sfh_finish u_finish (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_valid),
    .req_i        (req),
    .req_ready_o  (req_ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .hash_value_o (hash_value_o)
  );

endmodule
